/* sv/fcsg_pkg.sv */
`timescale 1ns / 1ps
// shared types and helpers for the filled-circle span generator
// no dependencies; used by fcsg_span_pipe, filled_circle_span_generator, fcsg_span_checker and tb_top

package fcsg_pkg;

	localparam int COORD_W = 8;
	localparam int DIAM_W  = 6;
	localparam int RAD_W   = 5;
	localparam int RSQ_W   = 10;
	localparam int OFS_W   = 6;
	localparam int OUT_W   = 10;
	localparam int ROOT_W  = 5;

	// one row in flight through the span pipeline
	typedef struct packed {
		logic signed [OFS_W-1:0] y;
		logic [RSQ_W-1:0]        rsq;
		logic [RSQ_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		logic [COORD_W-1:0]      cx;
		logic [COORD_W-1:0]      cy;
		logic                    last;
	} span_t;

	// one digit of the floor square root: keep the bit if the trial square still fits
	function automatic span_t sqrt_step(span_t p, logic [2:0] b);
		logic [ROOT_W-1:0] trial;
		logic [RSQ_W-1:0]  tsq;
		span_t             q;
		q     = p;
		trial = p.root | (ROOT_W'(1) << b);
		tsq   = RSQ_W'({5'd0, trial} * {5'd0, trial});
		if (tsq <= p.rem) begin
			q.root = trial;
		end
		return q;
	endfunction

endpackage

/* sv/fcsg_span_pipe.sv */
`timescale 1ns / 1ps
// row pipeline: offset squared, remainder, five square-root digit stages
// depends on fcsg_pkg

module fcsg_span_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  fcsg_pkg::span_t in_span,
	output logic           out_valid,
	output fcsg_pkg::span_t out_span
);
	import fcsg_pkg::*;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              valid_s5, valid_s6, valid_s7, valid_s8;
	span_t             span_s1, span_s2, span_s3, span_s4;
	span_t             span_s5, span_s6, span_s7, span_s8;
	logic [RSQ_W-1:0]  ysq_s2;
	logic [RAD_W-1:0]  yabs;
	span_t             rem_span;

	assign yabs = span_s1.y[OFS_W-1] ? RAD_W'(-span_s1.y) : RAD_W'(span_s1.y);

	always_comb begin
		rem_span      = span_s2;
		rem_span.rem  = span_s2.rsq - ysq_s2;
		rem_span.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s1 <= in_span;
			span_s2 <= span_s1;
			ysq_s2  <= RSQ_W'({5'd0, yabs} * {5'd0, yabs});
			span_s3 <= rem_span;
			span_s4 <= sqrt_step(span_s3, 3'd4);
			span_s5 <= sqrt_step(span_s4, 3'd3);
			span_s6 <= sqrt_step(span_s5, 3'd2);
			span_s7 <= sqrt_step(span_s6, 3'd1);
			span_s8 <= sqrt_step(span_s7, 3'd0);
		end
	end

	assign out_valid = valid_s8;
	assign out_span  = span_s8;

endmodule

/* sv/filled_circle_span_generator.sv */
`timescale 1ns / 1ps
// filled-circle span generator: one request in, 2r+1 spans out, top row first
// path: a request is registered in the row sequencer; each row then passes eight pipe registers and the output register
// throughput: one span per cycle while m_tready is high; s_tready stays low until the request's last row is issued
// (row sequencer issues one row per cycle, unless the output stalls, into a nine-register pipeline)
// reset: arst_n clears the sequencer and all valid bits; the block comes up idle
// depends on fcsg_pkg and fcsg_span_pipe

module filled_circle_span_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // center_x[7:0], center_y[15:8], diameter[21:16], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // row_y[9:0], left_x[19:10], right_x[29:20], zero
	output logic        m_tlast    // last_row
);
	import fcsg_pkg::*;

	logic                    busy_q;
	logic signed [OFS_W-1:0] y_q;
	logic [RAD_W-1:0]        r_q;
	logic [RSQ_W-1:0]        rsq_q;
	logic [COORD_W-1:0]      cx_q;
	logic [COORD_W-1:0]      cy_q;

	logic [COORD_W-1:0]      center_x;
	logic [COORD_W-1:0]      center_y;
	logic [DIAM_W-1:0]       diameter;
	logic [2*DIAM_W-1:0]     dsq;
	logic signed [OFS_W-1:0] neg_r;
	logic                    accept;
	logic                    en;
	logic                    issue;
	span_t                   issue_span;
	logic                    pipe_valid;
	span_t                   pipe_span;

	logic signed [OUT_W-1:0] row_y_q;
	logic signed [OUT_W-1:0] left_x_q;
	logic signed [OUT_W-1:0] right_x_q;
	logic                    last_row_q;
	logic                    m_tvalid_q;

	assign center_x = s_tdata[7:0];
	assign center_y = s_tdata[15:8];
	assign diameter = s_tdata[21:16];
	assign dsq      = {6'd0, diameter} * {6'd0, diameter};

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign en       = !m_tvalid_q || m_tready;
	assign issue    = busy_q && en;
	assign neg_r    = -$signed({1'b0, r_q});

	always_comb begin
		issue_span      = '0;
		issue_span.y    = y_q;
		issue_span.rsq  = rsq_q;
		issue_span.cx   = cx_q;
		issue_span.cy   = cy_q;
		issue_span.last = (y_q == neg_r);
	end

	// row sequencer: walks the offset from +r down to -r
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			y_q    <= '0;
			r_q    <= '0;
			rsq_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			r_q    <= diameter[DIAM_W-1:1];
			y_q    <= $signed({1'b0, diameter[DIAM_W-1:1]});
			rsq_q  <= dsq[2*DIAM_W-1:2];
			cx_q   <= center_x;
			cy_q   <= center_y;
		end else if (issue) begin
			if (y_q == neg_r) begin
				busy_q <= 1'b0;
			end else begin
				y_q <= y_q - OFS_W'(1);
			end
		end
	end

	fcsg_span_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (issue),
		.in_span  (issue_span),
		.out_valid(pipe_valid),
		.out_span (pipe_span)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && pipe_valid) begin
			row_y_q    <= $signed({2'b00, pipe_span.cy})
				+ OUT_W'(pipe_span.y);
			left_x_q   <= $signed({2'b00, pipe_span.cx})
				- $signed({5'd0, pipe_span.root});
			right_x_q  <= $signed({2'b00, pipe_span.cx})
				+ $signed({5'd0, pipe_span.root});
			last_row_q <= pipe_span.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, right_x_q, left_x_q, row_y_q};
	assign m_tlast  = last_row_q;

endmodule

/* dv/fcsg_span_checker.sv */
`timescale 1ns / 1ps
// span checker for filled_circle_span_generator: predicts the spans of every accepted
// request, compares the output stream against them in order and counts failures
// depends on fcsg_pkg

module fcsg_span_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,       // center_x[7:0], center_y[15:8], diameter[21:16], zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,       // row_y[9:0], left_x[19:10], right_x[29:20], zero
	input  logic        m_tlast,       // last_row
	output int          fail_count,
	output int          spans_waiting,
	output int          spans_checked
);
	import fcsg_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] row_y;
		logic [OUT_W-1:0] left_x;
		logic [OUT_W-1:0] right_x;
		logic             last_row;
	} span_rec_t;

	span_rec_t pending_spans[$];
	int        mismatch_cnt;
	int        compared_cnt;

	// floor integer square root, inputs stay below 1024
	function automatic int floor_root(int v);
		int t;
		t = 0;
		while (t < 31 && (t + 1) * (t + 1) <= v)
			t++;
		return t;
	endfunction

	// rows run from +r down to -r, half-width from the quarter-diameter-squared term
	task automatic predict_circle_spans(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [DIAM_W-1:0] diam);
		int        r;
		int        rsq;
		int        half;
		span_rec_t s;
		r   = int'(diam) / 2;
		rsq = (int'(diam) * int'(diam)) / 4;
		for (int y = r; y >= -r; y--) begin
			half       = floor_root(rsq - y * y);
			s.row_y    = OUT_W'(int'(cy) + y);
			s.left_x   = OUT_W'(int'(cx) - half);
			s.right_x  = OUT_W'(int'(cx) + half);
			s.last_row = (y == -r);
			pending_spans.push_back(s);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_rec_t got;
		span_rec_t want;
		if (!arst_n) begin
			pending_spans.delete();
			mismatch_cnt = 0;
			compared_cnt = 0;
			fail_count    <= 0;
			spans_waiting <= 0;
			spans_checked <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_circle_spans(s_tdata[7:0], s_tdata[15:8], s_tdata[21:16]);
			if (m_tvalid && m_tready) begin
				got.row_y    = m_tdata[9:0];
				got.left_x   = m_tdata[19:10];
				got.right_x  = m_tdata[29:20];
				got.last_row = m_tlast;
				if (pending_spans.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: span with nothing expected: row %0d x %0d..%0d last %0b",
							$time, $signed(got.row_y), $signed(got.left_x),
							$signed(got.right_x), got.last_row);
				end else begin
					want = pending_spans.pop_front();
					compared_cnt++;
					if (got !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%0t: exp %0d %0d..%0d %0b, got %0d %0d..%0d %0b",
								$time,
								$signed(want.row_y), $signed(want.left_x),
								$signed(want.right_x), want.last_row,
								$signed(got.row_y), $signed(got.left_x),
								$signed(got.right_x), got.last_row);
					end
				end
			end
			fail_count    <= mismatch_cnt;
			spans_waiting <= pending_spans.size();
			spans_checked <= compared_cnt;
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// testbench top for filled_circle_span_generator: clock, reset, circle requests and
// output back-pressure; checking is done by fcsg_span_checker, depends on fcsg_pkg

module tb_top;
	import fcsg_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RANDOM_ITEMS = 240;
	localparam int CYCLE_LIMIT  = 500000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;    // center_x[7:0], center_y[15:8], diameter[21:16], zero
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [31:0] m_tdata;          // row_y[9:0], left_x[19:10], right_x[29:20], zero
	logic        m_tlast;          // last_row

	int fail_count;
	int spans_waiting;
	int spans_checked;
	int requests_sent = 0;
	int cycle_cnt     = 0;
	bit src_no_gaps   = 1'b0;
	bit sink_no_stall = 1'b0;
	int stall_left    = 0;
	int sink_taken    = 0;

	filled_circle_span_generator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	fcsg_span_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.spans_waiting (spans_waiting),
		.spans_checked (spans_checked)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d spans still expected", cycle_cnt,
				spans_waiting);
			$display("tb_top: errors");
			$finish;
		end
	end

	// output back-pressure: after each taken span drop ready for a random stall length; sink_no_stall turns stalls off
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				if (stall_left == 1)
					m_tready <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				int n;
				n = sink_no_stall ? 0 : $urandom_range(0, 4);
				if (n != 0) begin
					m_tready   <= 1'b0;
					stall_left <= n;
				end
				sink_taken <= sink_taken + 1;
				if (sink_taken % 50 == 49)
					sink_no_stall <= ($urandom_range(0, 2) == 0);
			end
		end
	end

	// one request, held until taken; valid stays up when the next gap is zero
	task automatic send_circle(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [DIAM_W-1:0] diam);
		int gap;
		gap = src_no_gaps ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, diam, cy, cx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0:       return COORD_W'($urandom_range(0, 40));
			1:       return COORD_W'($urandom_range(215, 255));
			default: return COORD_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [DIAM_W-1:0] pick_diameter();
		case ($urandom_range(0, 9))
			0, 1:    return DIAM_W'($urandom_range(0, 7));
			2:       return DIAM_W'(63);
			default: return DIAM_W'($urandom_range(0, 63));
		endcase
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of the coordinate range, zero and full diameters, odd and even sizes
		send_circle(8'd0,   8'd0,   6'd0);
		send_circle(8'd255, 8'd255, 6'd0);
		send_circle(8'd0,   8'd0,   6'd63);
		send_circle(8'd255, 8'd255, 6'd63);
		send_circle(8'd0,   8'd255, 6'd1);
		send_circle(8'd255, 8'd0,   6'd2);
		send_circle(8'd3,   8'd4,   6'd3);
		send_circle(8'd250, 8'd2,   6'd4);
		send_circle(8'd1,   8'd1,   6'd62);
		send_circle(8'd128, 8'd127, 6'd31);
		send_circle(8'd170, 8'd85,  6'd42);
		send_circle(8'd85,  8'd170, 6'd21);
		send_circle(8'd16,  8'd240, 6'd32);
		send_circle(8'd240, 8'd16,  6'd33);
		send_circle(8'd255, 8'd0,   6'd63);
		send_circle(8'd0,   8'd255, 6'd63);
		send_circle(8'd100, 8'd100, 6'd5);
		send_circle(8'd200, 8'd50,  6'd0);
		send_circle(8'd0,   8'd0,   6'd1);
		send_circle(8'd255, 8'd255, 6'd2);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// alternate stretches of back-to-back requests with gapped ones
			if (i % 20 == 0)
				src_no_gaps = ($urandom_range(0, 2) == 0);
			send_circle(pick_coord(), pick_coord(), pick_diameter());
		end
		s_tvalid <= 1'b0;

		while (spans_waiting != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("summary: %0d circle requests, %0d spans compared, diameters 0..63",
			requests_sent, spans_checked);
		$display("summary: %0d failures, %0d spans left unmatched", fail_count,
			spans_waiting);
		if (fail_count == 0 && spans_waiting == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
